// ===== rtl/core/secant_flap_angle_update_unit_defines.svh =====
// Assertion macros shared by the secant flap angle update RTL.
// No dependencies; included by modules that carry assertions.
`ifndef SECANT_FLAP_ANGLE_UPDATE_UNIT_DEFINES_SVH
`define SECANT_FLAP_ANGLE_UPDATE_UNIT_DEFINES_SVH

// Clocked check, suspended while reset is asserted
`define SFAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define SFAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/sfau_pkg.sv =====
// Shared constants, types and the arctangent table for the flap angle unit.
// No dependencies.
package sfau_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int CORDIC_MAX_ITER       = 24;

    // serial divider widths: dividend magnitude and divisor
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 34;

    // angles in 1/64 degree
    localparam logic signed [16:0] TEN_DEG  = 17'sd640;
    localparam logic signed [16:0] FIVE_DEG = 17'sd320;
    localparam logic signed [16:0] DEG_90   = 17'sd5760;
    localparam logic signed [16:0] DEG_175  = 17'sd11200;
    localparam logic signed [16:0] DEG_180  = 17'sd11520;
    localparam logic signed [16:0] DEG_360  = 17'sd23040;

    localparam logic signed [32:0] PI_Q30   = 33'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // APB register indices
    localparam logic [1:0] REG_HINGE_X = 2'd0;
    localparam logic [1:0] REG_HINGE_Z = 2'd1;
    localparam logic [1:0] REG_SURFACE = 2'd2;
    localparam logic [1:0] REG_LENGTH  = 2'd3;

    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   num;
        logic [DIV_DW-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_NW-1:0]   quo;
    } t_div_rsp;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sfau_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sfau_pkg.
module sfau_div
    import sfau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_num, n_num;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy, r_done;
    logic [DIV_DW:0]   trial;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_num[DIV_NW-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
        n_num = {r_num[DIV_NW-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;

endmodule

// ===== rtl/core/sfau_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on sfau_pkg.
module sfau_cordic
    import sfau_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_z,
    output logic               o_done,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y
);

    localparam int NI = (CORDIC_ITERATIONS < CORDIC_MAX_ITER) ?
                        CORDIC_ITERATIONS : CORDIC_MAX_ITER;
    localparam int IW = $clog2(NI + 1);

    logic signed [33:0] r_x, r_y, r_z;
    logic [IW-1:0]      r_i;
    logic               r_busy, r_done;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({2'b00, atan_q30(5'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= GAIN_Q30;
                r_y    <= '0;
                r_z    <= i_z;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(NI - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// ===== rtl/core/secant_flap_angle_update_unit.sv =====
// A sample that is not last is taken in S_IDLE alone (first sample or equal moments) or
//   goes through the 17x32 product and the bit-serial divide; one item at a time.
// A last sample then goes through the clamp, the angle-to-radian divide, the CORDIC and the tip products,
//   which use the shared serial divider and the one-step-per-cycle CORDIC.
// A new sample may be taken while the result still waits in the output register.
// Reset (synchronous, active low) clears the configuration registers, the state machine, series state and o_valid.
module secant_flap_angle_update_unit
    import sfau_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample_angle,
    input  logic signed [31:0] i_sample_moment,
    input  logic               i_last_sample,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_best_angle,
    output logic signed [31:0] o_tip_x,
    output logic signed [31:0] o_tip_z,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_z,
    output logic               o_flat_fault,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "secant_flap_angle_update_unit_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_SMUL, S_SDIV0, S_SDIV, S_CLAMP, S_RED, S_AMUL, S_ADIV0,
        S_ADIV, S_ROT0, S_ROT, S_TXM, S_TZM, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_hinge_x, r_hinge_z;
    logic signed [14:0] r_surface;
    logic [30:0]        r_length;

    // series state
    logic signed [15:0] r_prev_angle, r_estimate, r_ang;
    logic signed [31:0] r_prev_moment, r_mom;
    logic               r_seen_first, r_fault_seen, r_last;

    // working registers
    logic signed [16:0] r_d, r_best;
    logic signed [32:0] r_dm;
    logic signed [66:0] r_prod;
    logic               r_qneg, r_zneg, r_flip, r_fault_o;
    logic [12:0]        r_mag;
    logic signed [33:0] r_c, r_s;
    logic signed [31:0] r_tx, r_tz;

    // multiplier, divider and CORDIC hookups
    logic signed [32:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [66:0] mul_p;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               cor_start, cor_done;
    logic signed [33:0] cor_x, cor_y, cor_z;

    logic               in_acc, apb_wr;
    logic signed [16:0] dang;
    logic signed [32:0] dmom;
    logic signed [66:0] prod_abs;
    logic signed [50:0] q_s, est_w;
    logic signed [16:0] lo_lim, hi_lim, red_r, fold_r;
    logic signed [33:0] z_s;
    logic signed [36:0] rnd;
    logic signed [37:0] coord;
    logic signed [34:0] nx_w, nz_w;
    logic signed [19:0] nx_r, nz_r;

    function automatic logic signed [15:0] sat16_51(input logic signed [50:0] v);
        logic signed [15:0] r;
        if (v > 51'sd32767)       r = 16'sh7FFF;
        else if (v < -51'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16_20(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)       r = 16'sh7FFF;
        else if (v < -20'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32_38(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (v < -38'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign apb_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // secant differences against the stored previous sample
    assign dang = 17'(i_sample_angle) - 17'(r_prev_angle);
    assign dmom = 33'(i_sample_moment) - 33'(r_prev_moment);

    // single shared multiplier, operands chosen by phase
    always_comb begin
        case (r_state)
            S_SMUL: begin
                mul_a = 33'(r_d);
                mul_b = 34'(r_mom);
            end
            S_AMUL: begin
                mul_a = PI_Q30;
                mul_b = $signed({21'd0, r_mag});
            end
            S_TXM: begin
                mul_a = $signed({2'b00, r_length});
                mul_b = r_c;
            end
            S_TZM: begin
                mul_a = $signed({2'b00, r_length});
                mul_b = r_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 67'(mul_a) * 67'(mul_b);
    end

    // divider requests: secant quotient magnitude, then degrees to radians
    always_comb begin
        prod_abs      = r_prod[66] ? -r_prod : r_prod;
        div_req.start = (r_state == S_SDIV0) || (r_state == S_ADIV0);
        if (r_state == S_SDIV0) begin
            div_req.num = prod_abs[DIV_NW-1:0];
            div_req.den = r_dm[32] ? DIV_DW'(-r_dm) : DIV_DW'(r_dm);
        end else begin
            div_req.num = r_prod[DIV_NW-1:0] + DIV_NW'(DEG_90);
            div_req.den = DIV_DW'(DEG_180);
        end
    end

    // quotient to estimate, limits, angle reduction
    always_comb begin
        q_s    = r_qneg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
        est_w  = 51'(r_ang) - q_s;
        lo_lim = 17'(r_surface) + FIVE_DEG;
        hi_lim = 17'(r_surface) + DEG_180;
        red_r  = r_best[16] ? r_best + DEG_360 : r_best;
        if (red_r >= DEG_180) red_r = red_r - DEG_360;
        if (red_r > DEG_90)          fold_r = red_r - DEG_180;
        else if (red_r < -DEG_90)    fold_r = red_r + DEG_180;
        else                         fold_r = red_r;
        z_s    = r_zneg ? -$signed({1'b0, div_rsp.quo[32:0]})
                        :  $signed({1'b0, div_rsp.quo[32:0]});
        rnd    = 37'((r_prod + 67'sd536870912) >>> 30);
        nx_w   = 35'sd16384 - 35'(r_s);
        nz_w   = 35'(r_c) + 35'sd16384;
        nx_r   = 20'(nx_w >>> 15);
        nz_r   = 20'(nz_w >>> 15);
    end

    // tip coordinate: hinge plus rounded product, saturated
    assign coord = (r_state == S_TZM) ? 38'(r_hinge_x) + 38'(rnd)
                                      : 38'(r_hinge_z) + 38'(rnd);

    assign cor_start = (r_state == S_ROT0);
    assign cor_z     = z_s;

    sfau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sfau_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_z     (cor_z),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    // register read-back
    always_comb begin
        case (paddr[3:2])
            REG_HINGE_X: prdata = r_hinge_x;
            REG_HINGE_Z: prdata = r_hinge_z;
            REG_SURFACE: prdata = 32'(r_surface);
            REG_LENGTH:  prdata = {1'b0, r_length};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_hinge_x     <= '0;
            r_hinge_z     <= '0;
            r_surface     <= '0;
            r_length      <= '0;
            r_prev_angle  <= '0;
            r_prev_moment <= '0;
            r_estimate    <= '0;
            r_seen_first  <= 1'b0;
            r_fault_seen  <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            if (apb_wr) begin
                case (paddr[3:2])
                    REG_HINGE_X: r_hinge_x <= pwdata;
                    REG_HINGE_Z: r_hinge_z <= pwdata;
                    REG_SURFACE: r_surface <= pwdata[14:0];
                    REG_LENGTH:  r_length  <= pwdata[30:0];
                    default: ;
                endcase
            end
            // the delivery phase handles o_valid itself
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ang         <= i_sample_angle;
                        r_mom         <= i_sample_moment;
                        r_last        <= i_last_sample;
                        r_d           <= dang;
                        r_dm          <= dmom;
                        r_prev_angle  <= i_sample_angle;
                        r_prev_moment <= i_sample_moment;
                        if (!r_seen_first) begin
                            r_estimate   <= sat16_51(51'(i_sample_angle) + 51'(TEN_DEG));
                            r_seen_first <= 1'b1;
                            r_state      <= i_last_sample ? S_CLAMP : S_IDLE;
                        end else if (dmom == '0) begin
                            r_fault_seen <= 1'b1;
                            r_state      <= i_last_sample ? S_CLAMP : S_IDLE;
                        end else begin
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_SMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_SDIV0;
                end
                S_SDIV0: begin
                    r_qneg  <= r_prod[66] ^ r_dm[32];
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    if (div_rsp.done) begin
                        r_estimate <= sat16_51(est_w);
                        r_state    <= r_last ? S_CLAMP : S_IDLE;
                    end
                end
                S_CLAMP: begin
                    // clamp against the surface, capture and close the series
                    if (17'(r_estimate) <= lo_lim) begin
                        r_best <= lo_lim;
                    end else if (17'(r_estimate) >= hi_lim) begin
                        r_best <= 17'(r_surface) + DEG_175;
                    end else begin
                        r_best <= 17'(r_estimate);
                    end
                    r_fault_o    <= r_fault_seen;
                    r_fault_seen <= 1'b0;
                    r_seen_first <= 1'b0;
                    r_state      <= S_RED;
                end
                S_RED: begin
                    r_flip  <= (fold_r != red_r);
                    r_zneg  <= fold_r[16];
                    r_mag   <= fold_r[16] ? 13'(-fold_r) : 13'(fold_r);
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_ADIV0;
                end
                S_ADIV0: r_state <= S_ADIV;
                S_ADIV: begin
                    if (div_rsp.done) r_state <= S_ROT0;
                end
                S_ROT0: r_state <= S_ROT;
                S_ROT: begin
                    if (cor_done) begin
                        r_c     <= r_flip ? -cor_x : cor_x;
                        r_s     <= r_flip ? -cor_y : cor_y;
                        r_state <= S_TXM;
                    end
                end
                S_TXM: begin
                    r_prod  <= mul_p;
                    r_state <= S_TZM;
                end
                S_TZM: begin
                    r_tx    <= sat32_38(coord);
                    r_prod  <= mul_p;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_tz    <= sat32_38(coord);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to be free
                    if (!o_valid || !i_stall) begin
                        o_valid      <= 1'b1;
                        o_best_angle <= r_best[15:0];
                        o_tip_x      <= r_tx;
                        o_tip_z      <= r_tz;
                        o_normal_x   <= sat16_20(nx_r);
                        o_normal_z   <= sat16_20(nz_r);
                        o_flat_fault <= r_fault_o;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a new result only comes out of the final delivery phase
    `SFAU_ASSERT(a_valid_from_out, $rose(o_valid) |-> $past(r_state == S_OUT), "result without delivery phase")
    // divider completes only in a phase that waits for it
    `SFAU_ASSERT(a_div_phase, div_rsp.done |-> (r_state == S_SDIV || r_state == S_ADIV), "stray divider completion")
    // CORDIC completes only while the rotation phase waits
    `SFAU_ASSERT(a_rot_phase, cor_done |-> (r_state == S_ROT), "stray CORDIC completion")
    // an accepted transaction that needs the secant step starts the multiplier
    `SFAU_ASSERT(a_acc_busy, (in_acc && r_seen_first && dmom != '0) |=> (r_state == S_SMUL), "secant step not started")

endmodule
